// ----- rtl/core/time_to_seven_segment_serial_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef TIME_TO_SEVEN_SEGMENT_SERIAL_MACROS_SVH
`define TIME_TO_SEVEN_SEGMENT_SERIAL_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define TTS7_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, but with the consequent sampled in the cycle after the antecedent.
`define TTS7_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tts7_pkg.sv -----
// Package: payload types, frame constants and digit encoding for the serial display driver.
`timescale 1ns / 1ps
package tts7_pkg;

  localparam int FRAME_BITS     = 64;
  localparam int DIGIT_BITS     = 16;
  localparam int DIGIT_COUNT    = FRAME_BITS / DIGIT_BITS;
  localparam int CNT_W          = $clog2(FRAME_BITS);
  localparam int DIGIT_W        = $clog2(DIGIT_COUNT);
  localparam int BIT_W          = $clog2(DIGIT_BITS);
  localparam logic [6:0] MAX_VALUE = 7'd99;
  localparam logic [3:0] BLANK_CODE = 4'd10;

  typedef struct packed {
    logic [6:0] minutes;
    logic [6:0] seconds;
  } in_t;

  typedef struct packed {
    logic       serial_data;
    logic       latch_strobe;
    logic [1:0] digit_index;
    logic       last;
  } out_t;

  // Saturate a 7-bit value to 99.
  function automatic logic [6:0] clamp99(input logic [6:0] v);
    return (v > MAX_VALUE) ? MAX_VALUE : v;
  endfunction

  // Tens digit of 0..99 by reciprocal multiply: (v * 205) >> 11.
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] prod;
    prod = 15'(v) * 15'd205;
    return prod[14:11];
  endfunction

  // Units digit: v - 10 * tens.
  function automatic logic [3:0] units_of(input logic [6:0] v);
    logic [6:0] t10;
    t10 = 7'(tens_of(v)) * 7'd10;
    return 4'(v - t10);
  endfunction

  // Active-low digit select byte per digit position.
  function automatic logic [7:0] select_byte(input logic [1:0] d);
    logic [7:0] b;
    unique case (d)
      2'd0:    b = 8'hF7;
      2'd1:    b = 8'hFB;
      2'd2:    b = 8'hFD;
      default: b = 8'hFE;
    endcase
    return b;
  endfunction

  // Active-low segments, bit0 = a .. bit6 = g, decimal point off; blank otherwise.
  function automatic logic [7:0] segment_byte(input logic [3:0] code);
    logic [7:0] b;
    unique case (code)
      4'd0:    b = 8'hC0;
      4'd1:    b = 8'hF9;
      4'd2:    b = 8'hA4;
      4'd3:    b = 8'hB0;
      4'd4:    b = 8'h99;
      4'd5:    b = 8'h92;
      4'd6:    b = 8'h82;
      4'd7:    b = 8'hF8;
      4'd8:    b = 8'h80;
      4'd9:    b = 8'h90;
      default: b = 8'hFF;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/tts7_cell.sv -----
// One bit cell of the frame shift line: loads in parallel or takes its neighbor's bit.
`timescale 1ns / 1ps
module tts7_cell (
  input  logic clk,
  input  logic load,
  input  logic shift,
  input  logic load_bit,
  input  logic prev_bit,
  output logic data_bit
);

  // Parallel load has priority over the shift
  always_ff @(posedge clk) begin
    if (load) begin
      data_bit <= load_bit;
    end else if (shift) begin
      data_bit <= prev_bit;
    end
  end

endmodule

// ----- rtl/core/time_to_seven_segment_serial.sv -----
// Top level: time value to 64-bit serial seven-segment stream through a row of bit cells.
//
//   channel   direction  handshake                 payload
//   command   in         start, busy               operand (minutes, seconds)
//   result    out        done                      result (serial_data, latch_strobe,
//                                                  digit_index, last)
//
// Each command yields 64 results on consecutive cycles; the transfer loads the
// cell row and sets active, and the output register then presents the first
// bit. The 64-cell shift line moves one bit out per cycle. busy drops while the
// final bit is shifted out, so a new command taken then continues the stream with
// no gap. Synchronous reset stops any run in progress; the receiver cannot stall.
`timescale 1ns / 1ps
module time_to_seven_segment_serial
  import tts7_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  operand,
  output logic done,
  output out_t result
);

  logic                   active;
  logic [CNT_W-1:0]       cnt;
  logic                   accept;
  logic                   shift;
  logic [FRAME_BITS-1:0]  frame;
  logic [FRAME_BITS-1:0]  cells;
  logic [3:0]             digit [DIGIT_COUNT];
  logic [6:0]             mins;
  logic [6:0]             secs;
  logic                   at_end;

  assign at_end = (cnt == CNT_W'(FRAME_BITS - 1));
  assign busy   = active && !at_end;
  assign accept = start && !busy;
  assign shift  = active;

  // Digit split with saturation; a zero minutes tens digit is blank
  always_comb begin
    mins     = clamp99(operand.minutes);
    secs     = clamp99(operand.seconds);
    digit[0] = units_of(secs);
    digit[1] = tens_of(secs);
    digit[2] = units_of(mins);
    digit[3] = (tens_of(mins) == 4'd0) ? BLANK_CODE : tens_of(mins);
  end

  // Frame image: digit 0 word in the top bits, each word select byte then segments
  always_comb begin
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      frame[FRAME_BITS-1-d*DIGIT_BITS -: DIGIT_BITS] =
        {select_byte(DIGIT_W'(d)), segment_byte(digit[d])};
    end
  end

  // Row of cells; the top cell is the head of the stream
  for (genvar i = 0; i < FRAME_BITS; i++) begin : g_cell
    tts7_cell u_cell (
      .clk      (clk),
      .load     (accept),
      .shift    (shift),
      .load_bit (frame[i]),
      .prev_bit ((i == 0) ? 1'b1 : cells[(i == 0) ? 0 : i-1]),
      .data_bit (cells[i])
    );
  end

  // Run control: bit counter and active flag
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (accept) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      active <= !at_end;
      cnt    <= cnt + CNT_W'(1);
    end
  end

  // Output register, one strobe per emitted bit
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      result.serial_data  <= cells[FRAME_BITS-1];
      result.latch_strobe <= (cnt[BIT_W-1:0] == BIT_W'(DIGIT_BITS - 1));
      result.digit_index  <= cnt[CNT_W-1 -: DIGIT_W];
      result.last         <= at_end;
    end
  end

endmodule

// ----- rtl/core/tts7_checker.sv -----
// Port-level checker for the serial display driver, bound to the top level.
`timescale 1ns / 1ps
`include "time_to_seven_segment_serial_macros.svh"
module tts7_checker
  import tts7_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input out_t result
);

  logic accept_seen;
  assign accept_seen = start && !busy;

  // A transfer starts the stream once the cells are loaded and the output register has taken the first bit
  `TTS7_ASSERT(a_first_bit, clk, rst, accept_seen |-> ##2 done, "no result after command")

  // A run never breaks before its final bit
  `TTS7_ASSERT_NEXT(a_no_gap, clk, rst, done && !result.last, done, "gap inside a run")

  // Final bit closes the last digit
  `TTS7_ASSERT(a_last_digit, clk, rst,
    (done && result.last) |-> (result.latch_strobe && result.digit_index == 2'd3),
    "final bit not at end of last digit")

  // Digit index steps after each latch inside a run
  `TTS7_ASSERT_NEXT(a_digit_step, clk, rst,
    done && result.latch_strobe && !result.last,
    result.digit_index == 2'($past(result.digit_index) + 2'd1),
    "digit index did not advance")

endmodule

bind time_to_seven_segment_serial tts7_checker u_tts7_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);
